@@ rtl/core/sha_pkg.sv @@
// shared types, constants and round functions for the sha-256 stream hasher
// no dependencies; used by every module of the hasher
`default_nettype none

package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_overflow;
  } result_t;

  // one 32-bit message word handed from the front end to the round engine
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        overflow;
  } xfer_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QW     = $clog2(QDEPTH);

  localparam logic [60:0] COUNT_MAX    = {61{1'b1}};
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [3:0]  LEN_WORD_IDX = 4'd14;

  function automatic logic [31:0] hash_init(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha_front.sv @@
// front end: takes byte items, counts length, packs words and generates padding
// depends on sha_pkg; feeds sha_fifo
`default_nettype none

module sha_front
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       q_push,
  input  wire logic  q_full,
  output xfer_t      q_data
);

  typedef enum logic [2:0] {ACCEPT, PAD_FIRST, PAD_ZERO, PAD_LEN_HI, PAD_LEN_LO} state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic        overflow;
  logic [31:0] word;
  logic [3:0]  pidx;

  logic        accept;
  logic        take;
  logic [31:0] word_new;
  logic [31:0] pad_first;
  logic [63:0] bit_len;

  assign full     = (state != ACCEPT) || q_full;
  assign accept   = push && !full;
  assign take     = accept && item.byte_present && (byte_count != COUNT_MAX);
  assign word_new = {word[23:0], item.data_byte};
  assign bit_len  = {byte_count, 3'b000};

  always_comb begin
    case (fill[1:0])
      2'd0:    pad_first = {PAD_MARK, 24'h0};
      2'd1:    pad_first = {word[7:0], PAD_MARK, 16'h0};
      2'd2:    pad_first = {word[15:0], PAD_MARK, 8'h0};
      default: pad_first = {word[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    q_push        = 1'b0;
    q_data.word   = word_new;
    q_data.last   = 1'b0;
    q_data.overflow = overflow;
    unique case (state)
      ACCEPT: begin
        q_push = take && (fill[1:0] == 2'd3);
      end
      PAD_FIRST: begin
        q_push      = 1'b1;
        q_data.word = pad_first;
      end
      PAD_ZERO: begin
        q_push      = (pidx != LEN_WORD_IDX);
        q_data.word = 32'h0;
      end
      PAD_LEN_HI: begin
        q_push      = 1'b1;
        q_data.word = bit_len[63:32];
      end
      PAD_LEN_LO: begin
        q_push      = 1'b1;
        q_data.word = bit_len[31:0];
        q_data.last = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ACCEPT;
      fill       <= '0;
      byte_count <= '0;
      overflow   <= 1'b0;
      pidx       <= '0;
    end else begin
      unique case (state)
        ACCEPT: begin
          if (accept) begin
            if (take) begin
              word       <= word_new;
              fill       <= fill + 6'd1;
              byte_count <= byte_count + 61'd1;
            end else if (item.byte_present) begin
              overflow <= 1'b1;
            end
            if (item.end_of_message) begin
              state <= PAD_FIRST;
            end
          end
        end
        PAD_FIRST: begin
          if (!q_full) begin
            pidx  <= fill[5:2] + 4'd1;
            state <= PAD_ZERO;
          end
        end
        PAD_ZERO: begin
          // zero words run up to the length slot, wrapping into a second block if needed
          if (pidx == LEN_WORD_IDX) begin
            state <= PAD_LEN_HI;
          end else if (!q_full) begin
            pidx <= pidx + 4'd1;
          end
        end
        PAD_LEN_HI: begin
          if (!q_full) begin
            state <= PAD_LEN_LO;
          end
        end
        PAD_LEN_LO: begin
          if (!q_full) begin
            state      <= ACCEPT;
            fill       <= '0;
            byte_count <= '0;
            overflow   <= 1'b0;
          end
        end
        default: begin
          state <= ACCEPT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sha_fifo.sv @@
// short word queue between the front end and the round engine
// depends on sha_pkg for the entry type and depth
`default_nettype none

module sha_fifo
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire xfer_t wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output xfer_t      rd_data,
  output logic       empty
);

  xfer_t         entries [QDEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == (QW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sha_core.sv @@
// back end: loads 16 words, runs 64 rounds one per cycle, updates the hash
// and hands out the digest words; depends on sha_pkg
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire xfer_t q_data,
  output logic       q_pop,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result
);

  typedef enum logic [1:0] {LOAD, ROUND, UPDATE, EMIT} state_t;

  state_t      state;
  logic [31:0] win  [16];
  logic [31:0] v    [8];
  logic [31:0] hash [8];
  logic [3:0]  load_cnt;
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic        last_blk;
  logic        ovf;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] ch;
  logic [31:0] maj;

  assign q_pop = (state == LOAD) && !q_empty;
  assign empty = (state != EMIT);

  assign result.digest_word     = hash[idx];
  assign result.word_index      = idx;
  assign result.last_word       = (idx == 3'd7);
  assign result.length_overflow = ovf;

  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + big_sigma1(v[4]) + ch + round_k(rnd) + win[0];
  assign t2    = big_sigma0(v[0]) + maj;
  // window holds w[i..i+15]; next schedule word is w[i+16]
  assign w_new = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= LOAD;
      load_cnt <= '0;
      rnd      <= '0;
      idx      <= '0;
      last_blk <= 1'b0;
      ovf      <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash_init(3'(i));
      end
    end else begin
      unique case (state)
        LOAD: begin
          if (q_pop) begin
            for (int i = 0; i < 15; i++) begin
              win[i] <= win[i+1];
            end
            win[15]  <= q_data.word;
            load_cnt <= load_cnt + 4'd1;
            if (load_cnt == 4'd15) begin
              last_blk <= q_data.last;
              ovf      <= q_data.overflow;
              rnd      <= '0;
              for (int i = 0; i < 8; i++) begin
                v[i] <= hash[i];
              end
              state <= ROUND;
            end
          end
        end
        ROUND: begin
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          idx   <= '0;
          state <= last_blk ? EMIT : LOAD;
        end
        EMIT: begin
          if (pop) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[i] <= hash_init(3'(i));
              end
              state <= LOAD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256_stream_hasher_top.sv @@
// sha-256 stream hasher: byte items in, eight digest words out per message
// an item is taken when push is high and full is low; full holds items off while padding
// words go out and while the 4-word queue is full. a 64-byte block costs 16 loads, 64
// rounds and one update; bytes sent back to back stall during the rounds, as only 16 bytes
// fit in the queue. end of message adds 3 to 18 words, held back while the queue is full;
// digest words follow the last update, one per pop. sync reset restores the iv
// depends on sha_pkg, sha_front, sha_fifo, sha_core
`default_nettype none

module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result
);

  logic  q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  xfer_t q_wr;
  xfer_t q_rd;

  sha_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wr)
  );

  sha_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  sha_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
